/* sv/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes of the positional array list: request and result
// layouts, operation and status codes, controller to datapath signal groups.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int PAL_CAPACITY = 128;

    typedef logic [2:0] t_func;
    localparam t_func FN_INSERT   = 3'd0;
    localparam t_func FN_DELETE   = 3'd1;
    localparam t_func FN_RETRIEVE = 3'd2;
    localparam t_func FN_SEARCH   = 3'd3;
    localparam t_func FN_CLEAR    = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_BADPOS = 2'd2;
    localparam t_status ST_EMPTY  = 2'd3;

    typedef struct packed {
        t_func              func;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_pal_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] read_value;
        logic [7:0]         found_position;
        logic               found;
        logic [7:0]         count;
        logic               is_empty;
        logic               is_full;
    } t_pal_res;

    typedef struct packed {
        logic load;
        logic init;
        logic shift_up;
        logic shift_dn;
        logic flush;
        logic retrieve;
        logic scan;
        logic finish;
    } t_pal_cmd;

    typedef struct packed {
        t_func op;
        logic  req_ok;
        logic  shift_none;
        logic  walk_last;
        logic  scan_hit;
        logic  scan_end;
        logic  list_empty;
    } t_pal_sts;

endpackage

/* sv/pal_ctrl.sv */
// ----------------------------------------------------------------------------
// pal_ctrl
// Controller of the positional array list: sequences decode, shift walks,
// search scan and result write-out of one transaction at a time.
// ----------------------------------------------------------------------------
module pal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pal_pkg::t_pal_sts i_sts,
    output pal_pkg::t_pal_cmd o_cmd,
    output logic              o_busy
);
    import pal_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_SHIFT_UP = 7'b0000100,
        S_SHIFT_DN = 7'b0001000,
        S_FLUSH    = 7'b0010000,
        S_SCAN     = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.init = 1'b1;
                n_state    = S_DONE;
                if (i_sts.req_ok) begin
                    case (i_sts.op)
                        FN_INSERT: begin
                            if (!i_sts.shift_none) begin
                                n_state = S_SHIFT_UP;
                            end
                        end
                        FN_DELETE: begin
                            if (!i_sts.shift_none) begin
                                n_state = S_SHIFT_DN;
                            end
                        end
                        FN_RETRIEVE: begin
                            o_cmd.retrieve = 1'b1;
                        end
                        FN_SEARCH: begin
                            if (!i_sts.list_empty) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SHIFT_UP: begin
                o_cmd.shift_up = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_SHIFT_DN: begin
                o_cmd.shift_dn = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit || i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* sv/pal_dp.sv */
// ----------------------------------------------------------------------------
// pal_dp
// Datapath of the positional array list: entry memory, count, walk index,
// pending shift write, search compare and the result register.
// ----------------------------------------------------------------------------
module pal_dp #(
    parameter int CAPACITY = pal_pkg::PAL_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pal_pkg::t_pal_req i_req,
    input  pal_pkg::t_pal_cmd i_cmd,
    output pal_pkg::t_pal_sts o_sts,
    output logic              o_done,
    output pal_pkg::t_pal_res o_res
);
    import pal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int WW = ((CW > 8) ? CW : 8) + 2;

    logic signed [31:0] mem [CAPACITY];

    t_func              r_func;
    logic [7:0]         r_pos;
    logic signed [31:0] r_val;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic               r_wr_pend;
    logic [AW-1:0]      r_wr_addr;
    logic signed [31:0] r_rd_data;
    logic               r_cv;
    logic [CW-1:0]      r_ci;
    logic               r_found;
    logic [WW-1:0]      r_fpos;
    logic               r_done;
    t_pal_res           r_res;

    logic [WW-1:0]      p_w;
    logic [WW-1:0]      c_w;
    logic [WW-1:0]      cap_w;
    logic [WW-1:0]      n_cw;
    logic               full_now;
    logic               empty_now;
    logic               pos_in;
    logic               pos_ins;
    logic               ins_ok;
    logic               del_ok;
    logic               ret_ok;
    logic [AW-1:0]      pos_m1;
    logic               scan_rd;
    logic               pend_wr;
    logic               put;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [31:0] mem_wd;
    logic               mem_re;
    logic [AW-1:0]      mem_ra;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      n_idx_init;
    t_pal_res           n_res;

    assign p_w       = WW'(r_pos);
    assign c_w       = WW'(r_count);
    assign cap_w     = WW'(CAPACITY);
    assign full_now  = (c_w == cap_w);
    assign empty_now = (c_w == '0);
    assign pos_in    = (p_w != '0) && (p_w <= c_w);
    assign pos_ins   = (p_w != '0) && (p_w <= c_w + WW'(1));
    assign ins_ok    = !full_now && pos_ins;
    assign del_ok    = !empty_now && pos_in;
    assign ret_ok    = pos_in;
    assign pos_m1    = AW'(p_w - WW'(1));

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_func;
        o_sts.list_empty = empty_now;
        case (r_func)
            FN_INSERT:   o_sts.req_ok = ins_ok;
            FN_DELETE:   o_sts.req_ok = del_ok;
            FN_RETRIEVE: o_sts.req_ok = ret_ok;
            default:     o_sts.req_ok = 1'b1;
        endcase
        if (r_func == FN_INSERT) begin
            o_sts.shift_none = (p_w == c_w + WW'(1));
            o_sts.walk_last  = (WW'(r_idx) == p_w - WW'(1));
        end else begin
            o_sts.shift_none = (p_w == c_w);
            o_sts.walk_last  = (WW'(r_idx) == c_w - WW'(1));
        end
        o_sts.scan_hit = r_cv && (r_rd_data == r_val);
        o_sts.scan_end = r_cv && (WW'(r_ci) == c_w - WW'(1));
    end

    // memory port control
    assign scan_rd = i_cmd.scan && (WW'(r_idx) < c_w);
    assign pend_wr = (i_cmd.shift_up || i_cmd.shift_dn || i_cmd.flush) && r_wr_pend;
    assign put     = i_cmd.finish && (r_func == FN_INSERT) && ins_ok;
    assign mem_we  = pend_wr || put;
    assign mem_wa  = put ? pos_m1 : r_wr_addr;
    assign mem_wd  = put ? r_val : r_rd_data;
    assign mem_re  = i_cmd.shift_up || i_cmd.shift_dn || i_cmd.retrieve || scan_rd;
    assign mem_ra  = i_cmd.retrieve ? pos_m1 : r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    always_comb begin
        case (r_func)
            FN_INSERT: n_idx_init = CW'(r_count - 1'b1);
            FN_DELETE: n_idx_init = CW'(p_w);
            default:   n_idx_init = '0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        case (r_func)
            FN_INSERT: begin
                if (ins_ok) begin
                    n_count = CW'(r_count + 1'b1);
                end
            end
            FN_DELETE: begin
                if (del_ok) begin
                    n_count = CW'(r_count - 1'b1);
                end
            end
            FN_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign n_cw = WW'(n_count);

    always_comb begin
        n_res                = '0;
        n_res.status         = ST_OK;
        case (r_func)
            FN_INSERT: begin
                if (full_now) begin
                    n_res.status = ST_FULL;
                end else if (!pos_ins) begin
                    n_res.status = ST_BADPOS;
                end
            end
            FN_DELETE: begin
                if (empty_now) begin
                    n_res.status = ST_EMPTY;
                end else if (!pos_in) begin
                    n_res.status = ST_BADPOS;
                end
            end
            FN_RETRIEVE: begin
                if (!ret_ok) begin
                    n_res.status = ST_BADPOS;
                end else begin
                    n_res.read_value = r_rd_data;
                end
            end
            FN_SEARCH: begin
                n_res.found_position = r_fpos[7:0];
                n_res.found          = r_found;
            end
            default: begin
                n_res.status = ST_OK;
            end
        endcase
        n_res.count    = n_cw[7:0];
        n_res.is_empty = (n_cw == '0);
        n_res.is_full  = (n_cw == cap_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_wr_pend <= 1'b0;
            r_cv      <= 1'b0;
            r_found   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.init) begin
                r_idx     <= n_idx_init;
                r_wr_pend <= 1'b0;
                r_cv      <= 1'b0;
                r_found   <= 1'b0;
            end
            if (i_cmd.shift_up) begin
                r_idx     <= CW'(r_idx - 1'b1);
                r_wr_pend <= 1'b1;
            end
            if (i_cmd.shift_dn) begin
                r_idx     <= CW'(r_idx + 1'b1);
                r_wr_pend <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_wr_pend <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_cv <= scan_rd;
                if (scan_rd) begin
                    r_idx <= CW'(r_idx + 1'b1);
                end
                if (o_sts.scan_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_req.func;
            r_pos  <= i_req.position;
            r_val  <= i_req.value;
        end
        if (i_cmd.init) begin
            r_fpos <= c_w + WW'(1);
        end
        if (i_cmd.shift_up) begin
            r_wr_addr <= AW'(r_idx + 1'b1);
        end
        if (i_cmd.shift_dn) begin
            r_wr_addr <= AW'(r_idx - 1'b1);
        end
        if (i_cmd.scan) begin
            if (scan_rd) begin
                r_ci <= r_idx;
            end
            if (o_sts.scan_hit) begin
                r_fpos <= WW'(r_ci) + WW'(1);
            end
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* sv/positional_array_list_unit.sv */
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Ordered list of signed 32-bit entries with insert, delete, retrieve,
// search and clear by 1-based position, kept in a single-port-read memory.
// ----------------------------------------------------------------------------
//  channel   ports                       transfer
//  request   i_start, o_busy, i_req      taken when i_start high and o_busy low
//  result    o_done, o_res               one cycle strobe, no back-pressure
//
//  after a request is taken the unit decodes it; an insert or delete that moves
//  entries then walks them through the memory and flushes the last write, a
//  search scans from the first entry to a hit or the last; then the result is set.
//  every entry move or compare uses the memory port.
//  o_busy drops in the cycle the strobe shows, a new request may enter there.
//  synchronous active-low reset empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
module positional_array_list_unit #(
    parameter int CAPACITY = pal_pkg::PAL_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  pal_pkg::t_pal_req i_req,
    output logic              o_done,
    output pal_pkg::t_pal_res o_res
);
    import pal_pkg::*;

    t_pal_cmd cmd;
    t_pal_sts sts;

    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    pal_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

/* sv/pal_checker.sv */
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks of the positional array list, bound to the top level.
// ----------------------------------------------------------------------------
module pal_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_done,
    input pal_pkg::t_pal_res o_res
);
    import pal_pkg::*;

    // an accepted transaction keeps the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    // result strobe only after the work is done
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    // single strobe per transaction
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // failed requests return no data
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != ST_OK) |-> (o_res.read_value == '0 && !o_res.found))
        else $error("error result carries data");

    // empty flag agrees with count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.is_empty) |-> (o_res.count == '0 && !o_res.is_full))
        else $error("empty flag disagrees with count");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (.*);
